[rtl/sckm_pkg.sv]
// ----------------------------------------------------------------------------
// Serial command keyword matcher package
// Keyword table, command codes and byte constants shared by the design.
// ----------------------------------------------------------------------------
package sckm_pkg;

   // Number of keywords and the byte width of one keyword text field.
   localparam int NUM_KEYS = 10;
   localparam int KEY_BYTES = 16;

   // Command codes, in keyword priority order, then the unknown code.
   typedef enum logic [3:0] {
      CMD_STOP          = 4'd0,
      CMD_START         = 4'd1,
      CMD_PWM_LOW       = 4'd2,
      CMD_PWM_MID       = 4'd3,
      CMD_PWM_HIGH      = 4'd4,
      CMD_DUTY_SET      = 4'd5,
      CMD_SERVO_A       = 4'd6,
      CMD_SERVO_MA      = 4'd7,
      CMD_SERVO_RCO     = 4'd8,
      CMD_SERVO_LEFT    = 4'd9,
      CMD_UNKNOWN       = 4'd10
   } command_code_type;

   // Special bytes.
   localparam logic [7:0] END_BYTE   = 8'h2E;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;

   // Preset duty values for the three pwm keywords.
   localparam logic [15:0] DUTY_WEEK   = 16'd20;
   localparam logic [15:0] DUTY_MID    = 16'd30;
   localparam logic [15:0] DUTY_STRONG = 16'd50;
   localparam logic [15:0] DUTY_LIMIT  = 16'd50;

   // The longest length a result reports.
   localparam logic [4:0] LEN_MAX = 5'd31;

   // One keyword text, padded with zero bytes at the top.
   typedef logic [8*KEY_BYTES-1:0] key_text_type;

   // Keyword text, right-aligned: the last character sits in the low byte.
   localparam key_text_type KEY_TEXT [NUM_KEYS] = '{
      key_text_type'("stop"),
      key_text_type'("start"),
      key_text_type'({"pwm_", "week"}),
      key_text_type'("pwm_mid"),
      key_text_type'({"pwm_", "strong"}),
      key_text_type'("d="),
      key_text_type'({"servomotor", "_a"}),
      key_text_type'({"servomotor", "_ma"}),
      key_text_type'({"servomotor", "_rco"}),
      key_text_type'({"servomotor", "_left"})
   };

   // Keyword lengths in bytes.
   localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
      4'd4, 4'd5, 4'd8, 4'd7, 4'd10, 4'd2, 4'd12, 4'd13, 4'd14, 4'd15
   };

   // Character of keyword key at position pos; pos must be below its length.
   function automatic logic [7:0] key_char(input int key, input logic [3:0] pos);
      logic [3:0] offset;
      offset = KEY_LEN[key] - 4'd1 - pos;
      return KEY_TEXT[key][8*offset +: 8];
   endfunction

endpackage

[rtl/sckm_req_if.sv]
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received serial byte per item.
// ----------------------------------------------------------------------------
interface sckm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/sckm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Command result channel
// Valid/ready channel that carries one decoded command per item.
// ----------------------------------------------------------------------------
interface sckm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command_code;
   logic [15:0] duty_value;
   logic [4:0]  message_length;

   modport source (output valid, output command_code, output duty_value,
                   output message_length, input ready);
   modport sink   (input valid, input command_code, input duty_value,
                   input message_length, output ready);
endinterface

[rtl/serial_command_keyword_matcher.sv]
// ----------------------------------------------------------------------------
// Serial command keyword matcher
// Matches dot-terminated serial messages against ten keywords on the fly
// and reports the command code, a duty value and the message length.
// ----------------------------------------------------------------------------
// Throughput: one byte item per clock cycle while results are taken.
// A result that waits stalls the input until it is taken.
// Latency: a result is valid in the cycle after its '.' item is accepted.
// The result register decides the rate: it is reloaded as it is taken.
// Reset clears the byte count and stored bytes, sets every keyword flag
// and empties the result register; no clearing pass is needed.
module serial_command_keyword_matcher #(
   parameter int COUNT_LIMIT = 31
) (
   input  logic             clock,
   input  logic             reset,
   sckm_req_if.sink         req_ch,
   sckm_rsp_if.source       rsp_ch
);
   import sckm_pkg::*;

   localparam int CW = $clog2(COUNT_LIMIT + 1);

   // Message state.
   logic [CW-1:0]       count_ff, count_in;
   logic [NUM_KEYS-1:0] flags_ff, flags_in;
   logic [7:0]          third_ff, third_in;
   logic [7:0]          fourth_ff, fourth_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   command_code_type    code_ff, code_in;
   logic [15:0]         duty_ff, duty_in;
   logic [4:0]          length_ff, length_in;

   logic                accept;
   logic                is_end;
   command_code_type    match_code;
   logic [15:0]         parsed_duty;
   logic [15:0]         digit_a, digit_b, tens_sum;
   logic [4:0]          length_sat;

   // A new item is taken whenever the result register is empty or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_end       = (req_ch.rx_byte == END_BYTE);

   // First keyword whose flag survives and whose length is reached.
   always_comb begin
      match_code = CMD_UNKNOWN;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (flags_ff[k] && (count_ff >= CW'(KEY_LEN[k]))) begin
            match_code = command_code_type'(4'(k));
         end
      end
   end

   // Two-digit duty parse from the stored third and fourth bytes.
   always_comb begin
      digit_a  = 16'(signed'(8'(third_ff - DIGIT_ZERO)));
      digit_b  = 16'(signed'(8'(fourth_ff - DIGIT_ZERO)));
      tens_sum = (digit_a << 3) + (digit_a << 1) + digit_b;
      if (tens_sum > DUTY_LIMIT) begin
         parsed_duty = digit_a;
      end else begin
         parsed_duty = tens_sum;
      end
   end

   // Reported length saturates at the field's top value.
   always_comb begin
      if (32'(count_ff) > 32'(LEN_MAX)) begin
         length_sat = LEN_MAX;
      end else begin
         length_sat = 5'(count_ff);
      end
   end

   // Next message state and result register contents.
   always_comb begin
      count_in     = count_ff;
      flags_in     = flags_ff;
      third_in     = third_ff;
      fourth_in    = fourth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      code_in      = code_ff;
      duty_in      = duty_ff;
      length_in    = length_ff;

      if (accept && is_end) begin
         // The terminator closes the message and loads a result.
         rsp_valid_in = 1'b1;
         code_in      = match_code;
         length_in    = length_sat;
         unique case (match_code)
            CMD_PWM_LOW:    duty_in = DUTY_WEEK;
            CMD_PWM_MID:    duty_in = DUTY_MID;
            CMD_PWM_HIGH:   duty_in = DUTY_STRONG;
            CMD_DUTY_SET:   duty_in = parsed_duty;
            default:        duty_in = 16'd0;
         endcase
         count_in = '0;
         flags_in = '1;
      end else if (accept && (count_ff < CW'(COUNT_LIMIT))) begin
         // Any other byte extends the message until the count is full.
         for (int k = 0; k < NUM_KEYS; k++) begin
            if ((count_ff < CW'(KEY_LEN[k])) &&
                (key_char(k, count_ff[3:0]) != req_ch.rx_byte)) begin
               flags_in[k] = 1'b0;
            end
         end
         if (count_ff == CW'(2)) begin
            third_in = req_ch.rx_byte;
         end else if (count_ff == CW'(3)) begin
            fourth_in = req_ch.rx_byte;
         end
         count_in = count_ff + CW'(1);
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flags_ff     <= '1;
         third_ff     <= '0;
         fourth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         third_ff     <= third_in;
         fourth_ff    <= fourth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff   <= code_in;
      duty_ff   <= duty_in;
      length_ff <= length_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.command_code   = code_ff;
   assign rsp_ch.duty_value     = duty_ff;
   assign rsp_ch.message_length = length_ff;

endmodule

[verif/serial_command_keyword_matcher_tb.sv]
// ----------------------------------------------------------------------------
// Serial command keyword matcher testbench
// Sends dot-terminated byte messages through the request channel and checks
// each decoded command against a predictor that tracks the keyword flags,
// the byte count and the stored duty digits. Directed messages come first,
// then random traffic under varying idle rates and receiver hold-offs.
// ----------------------------------------------------------------------------
module serial_command_keyword_matcher_tb;
   import sckm_pkg::*;

   localparam int MSG_LIMIT = 31;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct {
      command_code_type code;
      logic [15:0]      duty;
      logic [4:0]       len;
   } command_result_type;

   logic clock = 1'b0;
   logic reset;

   sckm_req_if req_bus ();
   sckm_rsp_if rsp_bus ();

   serial_command_keyword_matcher #(
      .COUNT_LIMIT (MSG_LIMIT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Keyword table in priority order, with the command each one decodes to.
   string keyword_text [NUM_KEYS] = '{
      "stop", "start", string'({"pwm_", "week"}), "pwm_mid",
      string'({"pwm_", "strong"}), "d=",
      string'({"servomotor", "_a"}), string'({"servomotor", "_ma"}),
      string'({"servomotor", "_rco"}), string'({"servomotor", "_left"})
   };
   command_code_type keyword_cmd [NUM_KEYS] = '{
      CMD_STOP, CMD_START, CMD_PWM_LOW, CMD_PWM_MID, CMD_PWM_HIGH,
      CMD_DUTY_SET, CMD_SERVO_A, CMD_SERVO_MA, CMD_SERVO_RCO, CMD_SERVO_LEFT
   };

   // Characters that keep random messages close to the keywords.
   string near_alphabet = "stoparwm_eekidgnlvc=0123456789";

   // Predictor state of the message being received.
   int                  msg_count = 0;
   logic [NUM_KEYS-1:0] match_flags = '1;
   logic [7:0]          stored_third = '0;
   logic [7:0]          stored_fourth = '0;

   command_result_type expected_cmds [$];
   int fault_count = 0;

   // Idle rates in percent and the receiver hold-off request.
   int send_idle_pct = 13;
   int recv_idle_pct = 45;
   int hold_len = 0;
   int hold_serial = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Clock with a period of four time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Duty from the two stored digit bytes, falling back to the tens digit.
   function automatic logic [15:0] parse_duty_digits();
      logic signed [7:0] tens;
      logic signed [7:0] units;
      int value;
      tens = stored_third - DIGIT_ZERO;
      units = stored_fourth - DIGIT_ZERO;
      value = 10 * int'(tens) + int'(units);
      if (value[15:0] > DUTY_LIMIT) return 16'(int'(tens));
      return value[15:0];
   endfunction

   // Advances the predictor by one accepted byte; a '.' queues a command.
   function automatic void track_byte(input logic [7:0] rx);
      command_result_type cmd;
      if (rx != END_BYTE) begin
         if (msg_count >= MSG_LIMIT) return;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (msg_count < keyword_text[k].len() && keyword_text[k][msg_count] != rx)
               match_flags[k] = 1'b0;
         end
         if (msg_count == 2) stored_third = rx;
         else if (msg_count == 3) stored_fourth = rx;
         msg_count++;
         return;
      end
      cmd.code = CMD_UNKNOWN;
      cmd.duty = '0;
      cmd.len = (msg_count > 31) ? LEN_MAX : 5'(msg_count);
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (match_flags[k] && msg_count >= keyword_text[k].len()) begin
            cmd.code = keyword_cmd[k];
            break;
         end
      end
      case (cmd.code)
         CMD_PWM_LOW:    cmd.duty = DUTY_WEEK;
         CMD_PWM_MID:    cmd.duty = DUTY_MID;
         CMD_PWM_HIGH:   cmd.duty = DUTY_STRONG;
         CMD_DUTY_SET:   cmd.duty = parse_duty_digits();
         default:        cmd.duty = '0;
      endcase
      expected_cmds.push_back(cmd);
      msg_count = 0;
      match_flags = '1;
   endfunction

   // Handshakes are sampled at the falling edge, where every signal is settled
   // for the rising edge that follows. Results are checked before the byte
   // of the same edge is predicted.
   always @(negedge clock) begin : monitor
      command_result_type want;
      if (reset === 1'b0) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected result: code %0d duty %0d length %0d", $time,
                        rsp_bus.command_code, rsp_bus.duty_value, rsp_bus.message_length);
               fault_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_bus.command_code !== want.code) begin
                  $display("%0t: command_code expected %0d, got %0d", $time, want.code,
                           rsp_bus.command_code);
                  fault_count++;
               end
               if (rsp_bus.duty_value !== want.duty) begin
                  $display("%0t: duty_value expected %0d, got %0d", $time, want.duty,
                           rsp_bus.duty_value);
                  fault_count++;
               end
               if (rsp_bus.message_length !== want.len) begin
                  $display("%0t: message_length expected %0d, got %0d", $time, want.len,
                           rsp_bus.message_length);
                  fault_count++;
               end
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) track_byte(req_bus.rx_byte);
      end
   end

   // Result receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic byte_queue_type text_bytes(input string text);
      byte_queue_type bytes;
      for (int i = 0; i < text.len(); i++) bytes.push_back(text[i]);
      return bytes;
   endfunction

   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == END_BYTE);
      return b;
   endfunction

   function automatic logic [7:0] near_char();
      return near_alphabet[$urandom_range(near_alphabet.len() - 1)];
   endfunction

   // Random message: mostly keywords and near misses, some noise and long ones.
   function automatic byte_queue_type random_message();
      byte_queue_type msg;
      string word;
      int kind;
      int extra;
      int spot;
      kind = $urandom_range(99);
      word = keyword_text[$urandom_range(NUM_KEYS - 1)];
      if (kind < 40) begin
         msg = text_bytes(word);
         extra = $urandom_range(3);
         repeat (extra) msg.push_back(($urandom_range(3) == 0) ? any_byte() : near_char());
      end else if (kind < 55) begin
         msg = text_bytes("d=");
         extra = $urandom_range(3);
         repeat (extra)
            msg.push_back(($urandom_range(4) == 0) ? any_byte()
                                                   : 8'(DIGIT_ZERO + $urandom_range(9)));
      end else if (kind < 72) begin
         msg = text_bytes(word);
         if ($urandom_range(1) == 1) begin
            spot = $urandom_range(word.len() - 1);
            while (msg.size() > spot) void'(msg.pop_back());
         end else begin
            spot = $urandom_range(word.len() - 1);
            msg[spot] = near_char();
         end
      end else if (kind < 84) begin
         extra = $urandom_range(8);
         repeat (extra) msg.push_back(any_byte());
      end else if (kind < 93) begin
         msg = text_bytes(word);
         extra = $urandom_range(28, 40);
         while (msg.size() < extra) msg.push_back(($urandom_range(1) == 1) ? any_byte()
                                                                          : near_char());
      end
      return msg;
   endfunction

   // Offers one byte after random idle cycles and returns once it is accepted.
   task automatic send_byte(input logic [7:0] b);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (taken !== 1'b1);
   endtask

   task automatic send_message(input byte_queue_type msg);
      foreach (msg[i]) send_byte(msg[i]);
      send_byte(END_BYTE);
   endtask

   // The sender pauses here until every queued command has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
   endtask

   // Every keyword exactly, in table order.
   task automatic test_keywords();
      for (int k = 0; k < NUM_KEYS; k++) send_message(text_bytes(keyword_text[k]));
   endtask

   // Empty, short, stale-digit, fallback, over-long and extreme-byte messages.
   task automatic test_special_cases();
      byte_queue_type msg;
      msg.delete();
      send_message(msg);
      send_message(text_bytes("d="));
      send_message(text_bytes("d=5"));
      send_message(text_bytes("d=50"));
      send_message(text_bytes("d=51"));
      send_message(text_bytes("d=99"));
      msg = text_bytes("d=");
      msg.push_back(8'h00);
      msg.push_back(8'hFF);
      send_message(msg);
      msg.delete();
      msg.push_back(8'h00);
      msg.push_back(8'hFF);
      msg.push_back(8'h7F);
      msg.push_back(8'h80);
      send_message(msg);
      send_message(text_bytes("stopx"));
      send_message(text_bytes("sto"));
      send_message(text_bytes("servomotor_"));
      send_message(text_bytes({"pwm_", "strongest"}));
      msg = text_bytes(keyword_text[NUM_KEYS - 1]);
      while (msg.size() < 31) msg.push_back(near_char());
      send_message(msg);
      msg.push_back(8'hFF);
      send_message(msg);
      msg = text_bytes(keyword_text[NUM_KEYS - 1]);
      while (msg.size() < 40) msg.push_back(any_byte());
      send_message(msg);
   endtask

   // Random messages at the given idle rates until the byte budget is used.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int byte_budget);
      byte_queue_type msg;
      int sent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < byte_budget) begin
         msg = random_message();
         send_message(msg);
         sent += msg.size() + 1;
      end
   endtask

   // Receiver holds off while short messages keep coming, so the input stalls.
   task automatic test_receiver_holdoff();
      byte_queue_type msg;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_len = 100;
      hold_serial++;
      repeat (40) begin
         msg.delete();
         if ($urandom_range(1) == 1) msg = text_bytes(keyword_text[$urandom_range(NUM_KEYS - 1)]);
         send_message(msg);
      end
      wait_for_results();
   endtask

   // Bursts of messages with the sender waiting for the results in between.
   task automatic test_drained_pause();
      repeat (3) begin
         repeat (8) send_message(random_message());
         wait_for_results();
      end
   endtask

   // Run ends a long way after the slowest correct run would have.
   initial begin
      #2_000_000;
      $display("serial_command_keyword_matcher_tb: errors");
      $finish;
   end

   initial begin : run_sequence
      int drain_cycles;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_keywords();
      test_special_cases();
      test_random_traffic(13, 45, 320);
      test_receiver_holdoff();
      test_random_traffic(45, 13, 320);
      test_drained_pause();
      test_random_traffic(0, 0, 320);

      // Let the last results drain, then allow a few spare cycles.
      req_bus.valid <= 1'b0;
      drain_cycles = 0;
      while (expected_cmds.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_cmds.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_cmds.size());
         fault_count += expected_cmds.size();
      end
      if (fault_count == 0) begin
         $display("serial_command_keyword_matcher_tb: clean");
      end else begin
         $display("serial_command_keyword_matcher_tb: errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/sckm_pkg.sv
rtl/sckm_req_if.sv
rtl/sckm_rsp_if.sv
rtl/serial_command_keyword_matcher.sv
verif/serial_command_keyword_matcher_tb.sv
